// ===== sv/shamd_pkg.sv =====
package shamd_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;

  // top level sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_HASH,
    S_OUT
  } top_state_t;

  // source of the byte pushed into the block
  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_ZERO,
    PH_LEN
  } phase_t;

  // round engine
  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_FOLD
  } core_state_t;

  // control from the byte packer to the round engine
  typedef struct packed {
    logic load;       // shift a finished word into the schedule window
    logic start;      // block complete, run the rounds
    logic init_chain; // digest delivered, back to initial hash
  } core_ctl_t;

  localparam logic [5:0] BlockLast = 6'd63;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [2:0] MaxBytes  = 3'd4;

  localparam word_t HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== sv/shamd_core.sv =====
module shamd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  shamd_pkg::core_ctl_t ctl,
  input  shamd_pkg::word_t    load_word,
  output logic                done,
  output shamd_pkg::hash_t    chain
);
  import shamd_pkg::*;

  core_state_t state_r, state_nxt;
  logic [5:0]  rnd_r;
  word_t       win_r [16];
  hash_t       vars_r;
  hash_t       chain_r;

  word_t sched_w, wj, t1, t2, ch, maj;
  word_t a, b, c, d, e, f, g, h;

  // round datapath, one round per cycle
  always_comb begin
    a = vars_r[0];
    b = vars_r[1];
    c = vars_r[2];
    d = vars_r[3];
    e = vars_r[4];
    f = vars_r[5];
    g = vars_r[6];
    h = vars_r[7];
    sched_w = win_r[0] + small_sigma0(win_r[1]) + win_r[9] + small_sigma1(win_r[14]);
    wj  = (rnd_r[5:4] == 2'b00) ? win_r[0] : sched_w;
    ch  = (e & f) ^ (~e & g);
    maj = (a & b) ^ (a & c) ^ (b & c);
    t1  = h + big_sigma1(e) + ch + RoundK[rnd_r] + wj;
    t2  = big_sigma0(a) + maj;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE:  if (ctl.start) state_nxt = C_ROUND;
      C_ROUND: if (rnd_r == 6'd63) state_nxt = C_FOLD;
      C_FOLD:  state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    done  = (state_r == C_FOLD);
    chain = chain_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.start) rnd_r <= '0;
      else if (state_r == C_ROUND) rnd_r <= rnd_r + 6'd1;
    end
  end

  // schedule window shifts: words from the packer, then the round schedule
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
      win_r[15] <= load_word;
    end else if (state_r == C_ROUND) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
      win_r[15] <= wj;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      vars_r <= chain_r;
    end else if (state_r == C_ROUND) begin
      vars_r[7] <= g;
      vars_r[6] <= f;
      vars_r[5] <= e;
      vars_r[4] <= d + t1;
      vars_r[3] <= c;
      vars_r[2] <= b;
      vars_r[1] <= a;
      vars_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init_chain) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= HashInit[i];
    end else if (state_r == C_FOLD) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + vars_r[i];
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> state_r == C_IDLE)
    else $error("block start while rounds running");

  a_fold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_ROUND && rnd_r == 6'd63) |=> state_r == C_FOLD)
    else $error("no fold after round 63");

endmodule

// ===== sv/sha256_message_digest_top.sv =====
// channel  | ports                          | beat contents
// ---------+--------------------------------+-------------------------------------------
// input    | in_tvalid in_tready in_tdata   | msg_word [31:0], byte_count [34:32]
//          | in_tlast                       | last_word
// output   | out_tvalid out_tready out_tdata| digest_word [31:0], word_index [34:32]
//          | out_tlast                      | digest_done
//
// flow: one beat is taken, then its valid bytes enter the block one per cycle
// while the round engine is not hashing a full block; each full 64-byte block
// runs 64 rounds in the round engine at one per cycle, then the chain fold.
// the last word adds padding bytes one per cycle, then eight digest beats.
// reset: synchronous rst_n clears the sequencer and counters and reloads the initial chain hash.
// stalls: in_tready is high only while idle, between message words; out_tvalid
// holds each digest beat until out_tready takes it.
module sha256_message_digest_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // msg_word [31:0], byte_count [34:32], zero [39:35]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word [31:0], word_index [34:32], zero [39:35]
  output logic        out_tlast
);
  import shamd_pkg::*;

  top_state_t  state_r, state_nxt;
  top_state_t  after_r, after_nxt;
  phase_t      phase_r, phase_nxt;

  logic [31:0] word_r;
  logic [2:0]  cnt_r;
  logic        last_r;
  logic [23:0] acc_r;
  logic [5:0]  fill_r;
  logic [60:0] msg_bytes_r;
  logic [63:0] len_r;
  logic [2:0]  idx_r;

  logic        in_fire, out_fire, push;
  logic [2:0]  cnt_in;
  logic [7:0]  push_byte;
  logic [5:0]  fill_inc;
  core_ctl_t   ctl;
  logic        core_done;
  hash_t       chain;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign push     = (state_r == S_PUSH);
  assign fill_inc = fill_r + 6'd1;
  // counts above four behave as four
  assign cnt_in   = (in_tdata[34:32] > MaxBytes) ? MaxBytes : in_tdata[34:32];

  // byte entering the block this cycle
  always_comb begin
    unique case (phase_r)
      PH_DATA: push_byte = word_r[31:24];
      PH_PAD:  push_byte = PadByte;
      PH_ZERO: push_byte = 8'h00;
      PH_LEN:  push_byte = len_r[63:56];
      default: push_byte = 8'h00;
    endcase
  end

  // where the sequence goes after this push, and which byte source follows
  always_comb begin
    after_nxt = S_PUSH;
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_DATA: begin
        if (cnt_r == 3'd1) begin
          if (last_r) phase_nxt = PH_PAD;
          else after_nxt = S_IDLE;
        end
      end
      PH_PAD, PH_ZERO: begin
        phase_nxt = (fill_inc == LenStart) ? PH_LEN : PH_ZERO;
      end
      PH_LEN: begin
        if (fill_r == BlockLast) after_nxt = S_OUT;
      end
      default: after_nxt = S_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (cnt_in != 3'd0 || in_tlast)) state_nxt = S_PUSH;
      end
      S_PUSH: state_nxt = (fill_r == BlockLast) ? S_HASH : after_nxt;
      S_HASH: if (core_done) state_nxt = after_r;
      S_OUT:  if (out_fire && idx_r == 3'd7) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready      = (state_r == S_IDLE);
    out_tvalid     = (state_r == S_OUT);
    out_tdata      = {5'b0, idx_r, chain[idx_r]};
    out_tlast      = (idx_r == 3'd7);
    ctl.load       = push && (fill_r[1:0] == 2'b11);
    ctl.start      = push && (fill_r == BlockLast);
    ctl.init_chain = out_fire && (idx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= S_IDLE;
      phase_r     <= PH_DATA;
      fill_r      <= '0;
      msg_bytes_r <= '0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        phase_r <= (cnt_in != 3'd0) ? PH_DATA : PH_PAD;
      end else if (push) begin
        phase_r <= phase_nxt;
        after_r <= after_nxt;
        fill_r  <= fill_inc;
        if (phase_r == PH_DATA) msg_bytes_r <= msg_bytes_r + 61'd1;
      end
      if (out_fire) begin
        idx_r <= idx_r + 3'd1;
        // digest delivered, next beat starts a new message
        if (idx_r == 3'd7) msg_bytes_r <= '0;
      end
    end
  end

  // byte datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= in_tdata[31:0];
      cnt_r  <= cnt_in;
      last_r <= in_tlast;
    end else if (push) begin
      acc_r <= {acc_r[15:0], push_byte};
      if (phase_r == PH_DATA) begin
        word_r <= {word_r[23:0], 8'h00};
        cnt_r  <= cnt_r - 3'd1;
      end
      if (phase_r != PH_LEN && phase_nxt == PH_LEN) len_r <= {msg_bytes_r, 3'b000};
      else if (phase_r == PH_LEN) len_r <= {len_r[55:0], 8'h00};
    end
  end

  shamd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .load_word ({acc_r, push_byte}),
    .done      (core_done),
    .chain     (chain)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input open while digest pending");

  a_block_on_word: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> ctl.load)
    else $error("block end off a word boundary");

  a_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> state_r == S_HASH)
    else $error("round engine finished outside hash wait");

  a_clean_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_tlast) |=> (state_r == S_IDLE && fill_r == 6'd0 && msg_bytes_r == '0))
    else $error("message state not cleared after digest");

endmodule
